// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/hcbd_pkg.sv -----
// Types, constants and helper functions for the chunked body decoder.
package hcbd_pkg;

	typedef enum logic [1:0] {
		PH_SIZE  = 2'd0,
		PH_DATA  = 2'd1,
		PH_TRAIL = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	localparam logic CFG_CHUNKED = 1'b0;
	localparam logic CFG_LENGTH  = 1'b1;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef struct packed {
		logic        hex_active;
		logic [31:0] size_acc;
		logic [31:0] bytes_rem;
		logic        trail_skip;
		logic [31:0] total;
	} dstate_t;

	localparam dstate_t DSTATE_CLR = '{
		hex_active: 1'b1,
		size_acc:   32'd0,
		bytes_rem:  32'd0,
		trail_skip: 1'b0,
		total:      32'd0
	};

	typedef struct packed {
		logic [7:0]  pl_byte;
		logic        pl_valid;
		logic        complete;
		logic [31:0] total;
	} result_t;

	// {is_hex, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/http_chunked_body_decoder.sv -----
// Top level of the HTTP/1.1 body decoder: input register, step logic, result register.
// An accepted word goes from the input register through the step logic into the result register.
// Throughput: one word and one step-logic state update per cycle while out_ready is high.
// in_ready stays high while out_ready is high; a full result register stalls the input register.
// Reset clears the decoder state, both registers' valid flags and the configuration to zero.
// first_of_body clears the decoder state, not the configuration, before its word is handled.
module http_chunked_body_decoder
	import hcbd_pkg::*;
#(
	parameter int unsigned LINE_BUFFER = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  body_byte,
	input  logic        first_of_body,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  payload_byte,
	output logic        payload_valid,
	output logic        body_complete,
	output logic [31:0] payload_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned LW = $clog2(LINE_BUFFER);

	logic          chunked_q;
	logic [31:0]   length_q;
	logic          v_s1;
	logic [7:0]    char_s1;
	logic          first_s1;
	logic          res_v_q;
	result_t       res_q;
	phase_t        phase_q;
	phase_t        phase_n;
	logic [LW-1:0] cnt_q;
	logic [LW-1:0] cnt_n;
	dstate_t       st_q;
	dstate_t       st_n;
	result_t       res_n;
	logic          adv;
	logic          fire;

	assign adv       = !res_v_q || out_ready;
	assign fire      = v_s1 && adv;
	assign in_ready  = !v_s1 || adv;
	assign cfg_ready = 1'b1;

	hcbd_step #(
		.LINE_BUFFER(LINE_BUFFER)
	) u_step (
		.chunked    (chunked_q),
		.length     (length_q),
		.in_char    (char_s1),
		.restart    (first_s1),
		.phase      (phase_q),
		.line_cnt   (cnt_q),
		.st         (st_q),
		.phase_n    (phase_n),
		.line_cnt_n (cnt_n),
		.st_n       (st_n),
		.res        (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_q <= 1'b0;
			length_q  <= 32'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CHUNKED: chunked_q <= cfg_data[0];
				CFG_LENGTH:  length_q  <= cfg_data;
				default:     chunked_q <= chunked_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			res_v_q <= 1'b0;
			phase_q <= PH_SIZE;
			cnt_q   <= '0;
			st_q    <= DSTATE_CLR;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				res_v_q <= v_s1;
			end
			if (fire) begin
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
				st_q    <= st_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1  <= body_byte;
			first_s1 <= first_of_body;
		end
		if (fire) begin
			res_q <= res_n;
		end
	end

	assign out_valid     = res_v_q;
	assign payload_byte  = res_q.pl_byte;
	assign payload_valid = res_q.pl_valid;
	assign body_complete = res_q.complete;
	assign payload_total = res_q.total;

endmodule

// ----- hw/rtl/hcbd_step.sv -----
// Next-state and result logic for one body word.
module hcbd_step
	import hcbd_pkg::*;
#(
	parameter int unsigned LINE_BUFFER = 32,
	localparam int unsigned LW = $clog2(LINE_BUFFER)
) (
	input  logic          chunked,
	input  logic [31:0]   length,
	input  logic [7:0]    in_char,
	input  logic          restart,
	input  phase_t        phase,
	input  logic [LW-1:0] line_cnt,
	input  dstate_t       st,
	output phase_t        phase_n,
	output logic [LW-1:0] line_cnt_n,
	output dstate_t       st_n,
	output result_t       res
);

	localparam logic [LW-1:0] KEEP_MAX = LW'(LINE_BUFFER - 1);

	phase_t        ph_e;
	logic [LW-1:0] cnt_e;
	dstate_t       st_e;
	logic [4:0]    hex;
	logic          is_lf;
	logic          keep;
	logic [31:0]   bytes_dec;
	logic          pass;
	logic [31:0]   total_n;

	assign ph_e      = restart ? PH_SIZE : phase;
	assign cnt_e     = restart ? '0 : line_cnt;
	assign st_e      = restart ? DSTATE_CLR : st;
	assign hex       = hex_decode(in_char);
	assign is_lf     = (in_char == CH_LF);
	assign keep      = !is_lf && (in_char != CH_CR) && (cnt_e < KEEP_MAX);
	assign bytes_dec = st_e.bytes_rem - 32'd1;

	always_comb begin
		phase_n = ph_e;
		if (chunked) begin
			unique case (ph_e)
				PH_SIZE: begin
					if (is_lf) begin
						phase_n = (st_e.size_acc == 32'd0) ? PH_DONE : PH_DATA;
					end
				end
				PH_DATA: begin
					if (bytes_dec == 32'd0) begin
						phase_n = PH_TRAIL;
					end
				end
				PH_TRAIL: begin
					if (st_e.trail_skip) begin
						phase_n = PH_SIZE;
					end
				end
				PH_DONE: begin
					phase_n = PH_DONE;
				end
				default: begin
					phase_n = ph_e;
				end
			endcase
		end
	end

	always_comb begin
		st_n       = st_e;
		line_cnt_n = cnt_e;
		pass       = 1'b0;
		if (chunked) begin
			unique case (ph_e)
				PH_SIZE: begin
					if (is_lf) begin
						if (st_e.size_acc != 32'd0) begin
							st_n.bytes_rem = st_e.size_acc;
						end
						line_cnt_n      = '0;
						st_n.hex_active = 1'b1;
						st_n.size_acc   = 32'd0;
					end else if (keep) begin
						line_cnt_n = cnt_e + 1'b1;
						if (st_e.hex_active) begin
							if (!hex[4]) begin
								st_n.hex_active = 1'b0;
							end else begin
								st_n.size_acc = {st_e.size_acc[27:0], hex[3:0]};
							end
						end
					end
				end
				PH_DATA: begin
					pass           = 1'b1;
					st_n.bytes_rem = bytes_dec;
					if (bytes_dec == 32'd0) begin
						st_n.trail_skip = 1'b0;
					end
				end
				PH_TRAIL: begin
					st_n.trail_skip = !st_e.trail_skip;
				end
				default: begin
					pass = 1'b0;
				end
			endcase
		end else begin
			pass = (length == 32'd0) || (st_e.total < length);
		end
		total_n    = st_e.total + {31'd0, pass};
		st_n.total = total_n;

		res.pl_byte  = pass ? in_char : 8'd0;
		res.pl_valid = pass;
		res.total    = total_n;
		res.complete = chunked ? (phase_n == PH_DONE)
			: ((length != 32'd0) && (total_n >= length));
	end

endmodule

// ----- hw/rtl/hcbd_checker.sv -----
// Port-level checker for the body decoder and its bind.
`include "assert_macros.svh"

module hcbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  payload_byte,
	input logic        payload_valid,
	input logic [31:0] payload_total
);

	`ASSERT_NEVER(a_drop_byte_zero, clk, arst_n, out_valid && !payload_valid && (payload_byte != 8'd0), "dropped word carries a nonzero byte")
	`ASSERT_CLKD(a_no_stall_in, clk, arst_n, out_ready |-> in_ready, "input stalled while output drains")
	`ASSERT_CLKD(a_hold_total, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(payload_total), "stalled result changed")

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.payload_byte  (payload_byte),
	.payload_valid (payload_valid),
	.payload_total (payload_total)
);

// ----- tb/sv/http_chunked_body_decoder_tb.sv -----
// Self-checking testbench for the HTTP/1.1 chunked and length-mode body decoder.
module http_chunked_body_decoder_tb
	import hcbd_pkg::*;
();

	localparam int LINE_BUF    = 32;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  body_byte;
	logic        first_of_body;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  payload_byte;
	logic        payload_valid;
	logic        body_complete;
	logic [31:0] payload_total;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;

	http_chunked_body_decoder #(.LINE_BUFFER(LINE_BUF)) dut (.*);

	// register copies and decoder state of the predictor
	logic        m_chunked;
	logic [31:0] m_length;
	phase_t      ph;
	logic [7:0]  line_kept;
	logic        hex_on;
	logic [31:0] size_acc;
	logic [31:0] bytes_left;
	logic        trail_one;
	logic [31:0] total_out;

	result_t     pending_results[$];
	logic [7:0]  body_bytes[$];

	int unsigned n_sent, n_checked, n_payload, n_complete, n_writes, errors, cycle_count;
	bit          gaps_on = 1'b1;
	bit          hold_req = 1'b0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d words still expected", cycle_count,
				pending_results.size());
			$display("http_chunked_body_decoder_tb: FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_decoder();
		ph         = PH_SIZE;
		line_kept  = 8'd0;
		hex_on     = 1'b1;
		size_acc   = 32'd0;
		bytes_left = 32'd0;
		trail_one  = 1'b0;
		total_out  = 32'd0;
	endfunction

	// {is hex digit, value}
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c inside {[8'h30:8'h39]})
			return {1'b1, c[3:0]};
		if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
			return {1'b1, c[3:0] + 4'd9};
		return 5'd0;
	endfunction

	function automatic result_t decode_byte(input logic [7:0] c, input logic restart);
		result_t    r;
		logic       pass;
		logic       done;
		logic [4:0] dig;
		pass = 1'b0;
		done = 1'b0;
		if (restart)
			clear_decoder();
		if (m_chunked) begin
			case (ph)
			PH_SIZE: begin
				if (c == CH_LF) begin
					if (size_acc == 32'd0) begin
						ph = PH_DONE;
					end else begin
						bytes_left = size_acc;
						ph = PH_DATA;
					end
					line_kept = 8'd0;
					hex_on    = 1'b1;
					size_acc  = 32'd0;
				end else if (c != CH_CR && line_kept < LINE_BUF - 1) begin
					line_kept = line_kept + 8'd1;
					if (hex_on) begin
						dig = nibble_of(c);
						if (!dig[4])
							hex_on = 1'b0;
						else
							size_acc = {size_acc[27:0], dig[3:0]};
					end
				end
			end
			PH_DATA: begin
				pass = 1'b1;
				bytes_left = bytes_left - 32'd1;
				if (bytes_left == 32'd0) begin
					ph = PH_TRAIL;
					trail_one = 1'b0;
				end
			end
			PH_TRAIL: begin
				if (trail_one) begin
					trail_one = 1'b0;
					ph = PH_SIZE;
				end else begin
					trail_one = 1'b1;
				end
			end
			default: ;
			endcase
			done = (ph == PH_DONE);
		end else begin
			pass = (m_length == 32'd0) || (total_out < m_length);
		end
		if (pass)
			total_out = total_out + 32'd1;
		if (!m_chunked)
			done = (m_length != 32'd0) && (total_out >= m_length);
		r.pl_byte  = pass ? c : 8'h00;
		r.pl_valid = pass;
		r.complete = done;
		r.total    = total_out;
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				pending_results.push_back(decode_byte(body_byte, first_of_body));
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result word with nothing expected: byte %0h total %0d",
						payload_byte, payload_total);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("payload_byte", want.pl_byte, payload_byte);
					check_field("payload_valid", want.pl_valid, payload_valid);
					check_field("body_complete", want.complete, body_complete);
					check_field("payload_total", want.total, payload_total);
					n_payload += want.pl_valid;
					n_complete += want.complete;
					n_checked++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- handshakes

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	initial begin : receiver
		int n;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				n = LONG_HOLD;
			end else begin
				n = pick_gap();
			end
			if (n == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end
		end
	end

	// leaves in_valid high so a following word can go out back to back
	task automatic send_word(input logic [7:0] b, input logic restart);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		body_byte <= b;
		first_of_body <= restart;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	task automatic send_text(input string s, input logic restart);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], restart && i == 0);
	endtask

	task automatic send_body(input logic restart);
		for (int i = 0; i < body_bytes.size(); i++)
			send_word(body_bytes[i], restart && i == 0);
		body_bytes.delete();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (n_checked < n_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_CHUNKED)
			m_chunked = val[0];
		else
			m_length = val;
		n_writes++;
	endtask

	// ---------------------------------------------------------------- body builders

	function automatic int sig_nibbles(input logic [31:0] v);
		int n;
		n = 1;
		while (n < 8 && (v >> (4 * n)) != 0)
			n++;
		return n;
	endfunction

	task automatic push_digit(input logic [3:0] d);
		if (d < 4'd10)
			body_bytes.push_back(8'h30 + d);
		else
			body_bytes.push_back(($urandom_range(0, 1) ? 8'h57 : 8'h37) + d);
	endtask

	task automatic push_hex(input logic [31:0] v, input int ndig);
		for (int k = ndig - 1; k >= 0; k--)
			push_digit(v[k * 4 +: 4]);
	endtask

	task automatic append_size_line(input logic [31:0] sz);
		int style;
		int pad;
		style = $urandom_range(0, 9);
		pad = 0;
		if (style == 0)
			pad = $urandom_range(1, 5);
		if (style == 1)
			pad = $urandom_range(LINE_BUF - 6, LINE_BUF + 4);
		repeat (pad) body_bytes.push_back(8'h30);
		if (style == 2) begin
			// top digit falls out of the 32-bit size
			push_digit(4'($urandom_range(1, 15)));
			push_hex(sz, 8);
		end else begin
			push_hex(sz, sig_nibbles(sz));
		end
		if (style == 3) begin
			body_bytes.push_back(8'h3B);
			repeat ($urandom_range(0, 6)) body_bytes.push_back(8'($urandom_range(33, 126)));
		end
		if (style == 4)
			body_bytes.push_back(CH_CR);
		if (style != 5)
			body_bytes.push_back(CH_CR);
		body_bytes.push_back(CH_LF);
	endtask

	task automatic gen_chunked_body();
		int sz;
		repeat ($urandom_range(0, 4)) begin
			sz = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 48);
			append_size_line(sz);
			repeat (sz) body_bytes.push_back(8'($urandom));
			if ($urandom_range(0, 7) != 0) begin
				body_bytes.push_back(CH_CR);
				body_bytes.push_back(CH_LF);
			end else begin
				repeat (2) body_bytes.push_back(8'($urandom));
			end
		end
		append_size_line(32'd0);
		repeat ($urandom_range(0, 3)) body_bytes.push_back(8'($urandom));
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_length_directed();
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'h55, 1'b0);
		write_reg(CFG_LENGTH, 32'd2);
		send_text("ABC", 1'b1);
	endtask

	task automatic test_chunked_directed();
		write_reg(CFG_CHUNKED, 32'd1);
		// LF and CR as data, then last chunk and a dropped byte
		send_text("2\015\n\n\015\015\n0\nZ", 1'b1);
		// size digits stop at the first non-hex character; any trailer bytes
		send_text("1g\nXab\n", 1'b1);
	endtask

	task automatic test_chunked_random(input int count);
		int goal;
		int kind;
		write_reg(CFG_CHUNKED, 32'd1);
		goal = n_sent + count;
		while (n_sent < goal) begin
			gaps_on = ($urandom_range(0, 4) != 0);
			kind = $urandom_range(0, 99);
			gen_chunked_body();
			if (kind >= 75 && kind < 88) begin
				repeat ($urandom_range(1, body_bytes.size() - 1)) void'(body_bytes.pop_back());
			end else if (kind >= 88) begin
				body_bytes.delete();
				repeat ($urandom_range(4, 30)) body_bytes.push_back(8'($urandom));
			end
			send_body($urandom_range(0, 15) != 0);
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_length_random(input int count);
		int goal;
		logic [31:0] len;
		write_reg(CFG_CHUNKED, 32'd0);
		goal = n_sent + count;
		while (n_sent < goal) begin
			case ($urandom_range(0, 4))
			0: len = 32'd0;
			1: len = 32'hFFFF_FFFF;
			2: len = 32'd1;
			default: len = $urandom_range(2, 40);
			endcase
			write_reg(CFG_LENGTH, len);
			repeat ($urandom_range(1, 4)) begin
				gaps_on = ($urandom_range(0, 4) != 0);
				repeat ($urandom_range(1, 45)) body_bytes.push_back(8'($urandom));
				send_body($urandom_range(0, 5) != 0);
			end
		end
		gaps_on = 1'b1;
	endtask

	// mode changes mid-body share the running count and the chunk state
	task automatic test_mode_switches(input int count);
		int goal;
		logic [31:0] len;
		goal = n_sent + count;
		while (n_sent < goal) begin
			write_reg(CFG_CHUNKED, $urandom);
			case ($urandom_range(0, 3))
			0: len = 32'd0;
			1: len = 32'hFFFF_FFFF;
			2: len = $urandom_range(1, 8);
			default: len = total_out + $urandom_range(0, 16);
			endcase
			write_reg(CFG_LENGTH, len);
			gen_chunked_body();
			send_body($urandom_range(0, 2) == 0);
		end
	endtask

	task automatic test_backpressure();
		int goal;
		write_reg(CFG_CHUNKED, 32'd1);
		gaps_on = 1'b0;
		hold_req = 1'b1;
		goal = n_sent + 80;
		while (n_sent < goal) begin
			gen_chunked_body();
			send_body(1'b1);
		end
		drain();
		gaps_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		int cut;
		write_reg(CFG_CHUNKED, 32'd1);
		repeat (3) begin
			gen_chunked_body();
			cut = $urandom_range(1, body_bytes.size() - 1);
			for (int i = 0; i < body_bytes.size(); i++) begin
				if (i == cut)
					drain();
				send_word(body_bytes[i], i == 0);
			end
			body_bytes.delete();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		body_byte <= 8'h00;
		first_of_body <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_CHUNKED;
		cfg_data <= 32'd0;
		m_chunked = 1'b0;
		m_length = 32'd0;
		clear_decoder();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_length_directed();
		test_chunked_directed();
		test_chunked_random(850);
		test_length_random(450);
		test_mode_switches(300);
		test_backpressure();
		test_sender_pause();

		drain();
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected words never came", pending_results.size());
			errors++;
		end
		$display("%0d body bytes sent, %0d result words checked, %0d register writes",
			n_sent, n_checked, n_writes);
		$display("%0d bytes delivered as payload, %0d words with the body marked complete",
			n_payload, n_complete);
		if (errors == 0) begin
			$display("http_chunked_body_decoder_tb: PASS");
		end else begin
			$display("http_chunked_body_decoder_tb: FAIL");
		end
		$finish;
	end

endmodule
